/* sv/ffrsc_pkg.sv */
package ffrsc_pkg;

    // Input function codes (carried on s_tuser)
    localparam logic [1:0] FUNC_BYTE = 2'd0;
    localparam logic [1:0] FUNC_TICK = 2'd1;
    localparam logic [1:0] FUNC_READ = 2'd2;

    // Short one-byte commands accepted while idle
    localparam logic [7:0] SHORT_CMD_A = 8'hFE;
    localparam logic [7:0] SHORT_CMD_B = 8'hFF;

    // Timeout register reset value
    localparam logic [7:0] TIMEOUT_RESET = 8'd50;

    // Default frame length in bytes (range 2..64)
    localparam int FRAME_BYTES_DEF = 8;

    // Field widths
    localparam int FUNC_W     = 2;
    localparam int BYTE_W     = 8;
    localparam int POS_W      = 6;
    localparam int TICK_W     = 9;
    localparam int OUT_DATA_W = 16;

    // Controller states: the frame phase plus the emit run of a read
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RECV,
        ST_READY,
        ST_EMIT
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic start_frame;  // first byte of a frame, or a short command
        logic short_cmd;    // first byte is a short command
        logic next_byte;    // further byte of a frame in progress
        logic tick;         // timer tick while receiving
        logic rd_start;     // fetch store entry 0 for a read run
        logic emit;         // load one frame byte into the output register
        logic not_ready;    // load the not-ready result
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic is_short;     // incoming byte is a short command
        logic count_last;   // incoming byte is the checksum position
        logic sum_ok;       // running sum matches incoming byte
        logic tick_expire;  // this tick passes the timeout
        logic emit_last;    // current emit byte is the final one
        logic out_free;     // output register can take a new item
    } status_t;

endpackage

/* sv/ffrsc_ctrl.sv */
module ffrsc_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic [ffrsc_pkg::FUNC_W-1:0]  func,
    input  ffrsc_pkg::status_t            status,
    output logic                          s_tready,
    output ffrsc_pkg::cmd_t               cmd
);
    import ffrsc_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    // Inputs are taken in any frame phase when the output side has room
    assign s_tready = (state_reg != ST_EMIT) && status.out_free;
    assign accept   = s_tvalid && s_tready;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && func == FUNC_BYTE) begin
                    state_next = status.is_short ? ST_READY : ST_RECV;
                end
            end
            ST_RECV: begin
                if (accept && func == FUNC_BYTE && status.count_last) begin
                    state_next = status.sum_ok ? ST_READY : ST_IDLE;
                end else if (accept && func == FUNC_TICK && status.tick_expire) begin
                    state_next = ST_IDLE;
                end
            end
            ST_READY: begin
                if (accept && func == FUNC_READ) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (status.out_free && status.emit_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Command outputs
    always_comb begin
        cmd = '0;
        case (state_reg)
            ST_IDLE: begin
                cmd.start_frame = accept && func == FUNC_BYTE;
                cmd.short_cmd   = accept && func == FUNC_BYTE && status.is_short;
                cmd.not_ready   = accept && func == FUNC_READ;
            end
            ST_RECV: begin
                cmd.next_byte = accept && func == FUNC_BYTE;
                cmd.tick      = accept && func == FUNC_TICK;
                cmd.not_ready = accept && func == FUNC_READ;
            end
            ST_READY: begin
                cmd.rd_start = accept && func == FUNC_READ;
            end
            ST_EMIT: begin
                cmd.emit = status.out_free;
            end
            default: cmd = '0;
        endcase
    end

endmodule

/* sv/ffrsc_dp.sv */
module ffrsc_dp #(
    parameter int FRAME_BYTES = ffrsc_pkg::FRAME_BYTES_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [ffrsc_pkg::BYTE_W-1:0]      cfg_wr_data,
    input  logic [ffrsc_pkg::BYTE_W-1:0]      rx_byte,
    input  ffrsc_pkg::cmd_t                   cmd,
    output ffrsc_pkg::status_t                status,
    input  logic                              m_tready,
    output logic                              m_tvalid,
    output logic                              m_frame_ready,
    output logic [ffrsc_pkg::BYTE_W-1:0]      m_frame_byte,
    output logic [ffrsc_pkg::POS_W-1:0]       m_byte_position,
    output logic                              m_last_byte
);
    import ffrsc_pkg::*;

    localparam int AW = $clog2(FRAME_BYTES);
    localparam logic [AW-1:0] LAST_IDX = AW'(FRAME_BYTES - 1);

    // Frame store: one write port, one registered read port
    logic [BYTE_W-1:0]      mem [FRAME_BYTES];
    logic [FRAME_BYTES-1:0] valid_reg;
    logic [BYTE_W-1:0]      rd_data_reg;

    logic [AW-1:0]     count_reg;
    logic [BYTE_W-1:0] sum_reg;
    logic [TICK_W-1:0] ticks_reg;
    logic [TICK_W-1:0] ticks_inc;
    logic [BYTE_W-1:0] timeout_reg;
    logic [AW-1:0]     idx_reg;

    logic              out_valid_reg;
    logic              out_ready_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic [POS_W-1:0]  out_pos_reg;
    logic              out_last_reg;

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;

    assign ticks_inc = ticks_reg + TICK_W'(1);

    // Status toward the controller
    assign status.is_short    = (rx_byte == SHORT_CMD_A) || (rx_byte == SHORT_CMD_B);
    assign status.count_last  = (count_reg == LAST_IDX);
    assign status.sum_ok      = (sum_reg == rx_byte);
    assign status.tick_expire = (ticks_inc > {1'b0, timeout_reg});
    assign status.emit_last   = (idx_reg == LAST_IDX);
    assign status.out_free    = !out_valid_reg || m_tready;

    // Store access
    assign wr_en   = cmd.start_frame || cmd.next_byte;
    assign wr_addr = cmd.start_frame ? '0 : count_reg;
    assign rd_en   = cmd.rd_start || (cmd.emit && !status.emit_last);
    assign rd_addr = cmd.rd_start ? '0 : idx_reg + AW'(1);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= rx_byte;
        end
        if (rd_en) begin
            rd_data_reg <= valid_reg[rd_addr] ? mem[rd_addr] : '0;
        end
    end

    // Entries never written read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    // Timeout register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= TIMEOUT_RESET;
        end else if (cfg_wr_en) begin
            timeout_reg <= cfg_wr_data;
        end
    end

    // Byte count, idle ticks and read index
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            ticks_reg <= '0;
            idx_reg   <= '0;
        end else begin
            if (cmd.start_frame) begin
                count_reg <= cmd.short_cmd ? '0 : AW'(1);
                ticks_reg <= '0;
            end else if (cmd.next_byte) begin
                count_reg <= status.count_last ? '0 : count_reg + AW'(1);
                ticks_reg <= '0;
            end else if (cmd.tick) begin
                if (status.tick_expire) begin
                    count_reg <= '0;
                    ticks_reg <= '0;
                end else begin
                    ticks_reg <= ticks_inc;
                end
            end
            if (cmd.rd_start) begin
                idx_reg <= '0;
            end else if (cmd.emit && !status.emit_last) begin
                idx_reg <= idx_reg + AW'(1);
            end
        end
    end

    // Running checksum over all bytes but the last
    always_ff @(posedge aclk) begin
        if (cmd.start_frame) begin
            sum_reg <= rx_byte;
        end else if (cmd.next_byte) begin
            sum_reg <= sum_reg + rx_byte;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit || cmd.not_ready) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_ready_reg <= 1'b1;
            out_byte_reg  <= rd_data_reg;
            out_pos_reg   <= POS_W'(idx_reg);
            out_last_reg  <= status.emit_last;
        end else if (cmd.not_ready) begin
            out_ready_reg <= 1'b0;
            out_byte_reg  <= '0;
            out_pos_reg   <= '0;
            out_last_reg  <= 1'b1;
        end
    end

    assign m_tvalid        = out_valid_reg;
    assign m_frame_ready   = out_ready_reg;
    assign m_frame_byte    = out_byte_reg;
    assign m_byte_position = out_pos_reg;
    assign m_last_byte     = out_last_reg;

endmodule

/* sv/fixed_frame_receiver_sum_check_core.sv */
// Channel   | Ports                                  | Contents
// ----------+----------------------------------------+------------------------------------
// input     | s_tvalid s_tready s_tdata s_tuser      | tdata: rx_byte; tuser: func
// result    | m_tvalid m_tready m_tdata m_tuser      | tdata: frame_byte, byte_position;
//           | m_tlast                                | tuser: frame_ready; tlast: last_byte
// config    | cfg_wr_en cfg_wr_data                  | timeout_ticks
//
// A read of a ready frame first fetches entry 0 through the frame store's registered
// read port, then sends one byte per cycle while the result is not stalled; input is
// held off meanwhile. Reset is synchronous; store entries start as zero through
// per-entry valid bits, so there is no clearing pass. A stalled result holds the
// output register, and new items wait until it is taken.
module fixed_frame_receiver_sum_check_core #(
    parameter int FRAME_BYTES = ffrsc_pkg::FRAME_BYTES_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration
    input  logic                                cfg_wr_en,
    input  logic [ffrsc_pkg::BYTE_W-1:0]        cfg_wr_data,
    // input items
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [ffrsc_pkg::BYTE_W-1:0]        s_tdata,   // [7:0] rx_byte
    input  logic [ffrsc_pkg::FUNC_W-1:0]        s_tuser,   // [1:0] func
    // result items
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [ffrsc_pkg::OUT_DATA_W-1:0]    m_tdata,   // [7:0] frame_byte, [13:8] pos
    output logic                                m_tuser,   // [0] frame_ready
    output logic                                m_tlast
);
    import ffrsc_pkg::*;

    cmd_t              cmd;
    status_t           status;
    logic [BYTE_W-1:0] frame_byte;
    logic [POS_W-1:0]  byte_position;

    ffrsc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .func     (s_tuser),
        .status   (status),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    ffrsc_dp #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .rx_byte         (s_tdata),
        .cmd             (cmd),
        .status          (status),
        .m_tready        (m_tready),
        .m_tvalid        (m_tvalid),
        .m_frame_ready   (m_tuser),
        .m_frame_byte    (frame_byte),
        .m_byte_position (byte_position),
        .m_last_byte     (m_tlast)
    );

    // Pack result fields, zero fill to whole bytes
    assign m_tdata = {(OUT_DATA_W - BYTE_W - POS_W)'(0), byte_position, frame_byte};

endmodule

/* sv/ffrsc_checker.sv */
module ffrsc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
        && $stable(m_tlast))
        else $error("result changed while stalled");

    // Not-ready result is a single zero item
    a_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tlast && m_tdata == 16'd0)
        else $error("malformed not-ready result");

    // Input is held off while a frame run is still going out; the final
    // byte of the run may leave alongside a new input item
    a_run_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tuser && !m_tlast |=>
        !s_tready || (m_tlast && m_tready))
        else $error("input taken during frame run");

    // No input while a result is stalled
    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while result stalled");

    // Frame run positions step by one
    a_pos_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tuser && !m_tlast ##1 m_tvalid |->
        m_tuser && m_tdata[13:8] == $past(m_tdata[13:8]) + 6'd1)
        else $error("frame run position skipped");

endmodule

bind fixed_frame_receiver_sum_check_core ffrsc_checker u_ffrsc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
